// ===== rtl/core/vpa_pkg.sv =====
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared constants, codes and types of the variable partition allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;

   localparam int MAX_PARTS = 32;
   localparam int IDX_W     = $clog2(MAX_PARTS);
   localparam int CNT_W     = $clog2(MAX_PARTS + 1);
   localparam int SIZE_W    = 16;

   localparam logic [SIZE_W-1:0] MEM_SIZE_RESET = '1;

   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_FREE  = 2'd1;
   localparam logic [1:0] FUNC_QUERY = 2'd2;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NO_SPACE  = 3'd1;
   localparam logic [2:0] ST_NO_HOLE   = 3'd2;
   localparam logic [2:0] ST_BAD_INDEX = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   localparam logic REG_FIT_MODE = 1'b0;
   localparam logic REG_MEM_SIZE = 1'b1;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_CHECK,
      CMD_SCAN,
      CMD_RESOLVE,
      CMD_TAKE,
      CMD_SPLIT,
      CMD_FREE,
      CMD_MNEXT,
      CMD_MPREV,
      CMD_QUERY
   } cmd_type;

   typedef struct packed {
      logic pre_fail;
      logic scan_last;
      logic found;
      logic exact;
      logic full;
      logic free_bad;
   } dp_sts_type;

endpackage

// ===== rtl/core/vpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// vpa_ctrl
// Sequencer: steps the datapath through allocate, free and query operations.
// ----------------------------------------------------------------------------
module vpa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_func,
   input  logic                rsp_slot_free,
   input  vpa_pkg::dp_sts_type sts,
   output vpa_pkg::cmd_type    cmd,
   output logic                req_ready,
   output logic                rsp_load
);
   import vpa_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE    = 11'b000_0000_0001,
      S_CHECK   = 11'b000_0000_0010,
      S_SCAN    = 11'b000_0000_0100,
      S_RESOLVE = 11'b000_0000_1000,
      S_TAKE    = 11'b000_0001_0000,
      S_SPLIT   = 11'b000_0010_0000,
      S_FREE    = 11'b000_0100_0000,
      S_MNEXT   = 11'b000_1000_0000,
      S_MPREV   = 11'b001_0000_0000,
      S_QUERY   = 11'b010_0000_0000,
      S_DONE    = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = CMD_NONE;
      rsp_load  = 1'b0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd = CMD_LOAD;
               unique case (req_func)
                  FUNC_ALLOC: state_in = S_CHECK;
                  FUNC_FREE:  state_in = S_FREE;
                  FUNC_QUERY: state_in = S_QUERY;
                  default:    state_in = S_DONE;
               endcase
            end
         end
         S_CHECK: begin
            cmd      = CMD_CHECK;
            state_in = sts.pre_fail ? S_DONE : S_SCAN;
         end
         S_SCAN: begin
            cmd = CMD_SCAN;
            if (sts.scan_last) begin
               state_in = S_RESOLVE;
            end
         end
         S_RESOLVE: begin
            cmd = CMD_RESOLVE;
            if (!sts.found) begin
               state_in = S_DONE;
            end else if (sts.exact) begin
               state_in = S_TAKE;
            end else if (sts.full) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SPLIT;
            end
         end
         S_TAKE: begin
            cmd      = CMD_TAKE;
            state_in = S_DONE;
         end
         S_SPLIT: begin
            cmd      = CMD_SPLIT;
            state_in = S_DONE;
         end
         S_FREE: begin
            cmd      = CMD_FREE;
            state_in = sts.free_bad ? S_DONE : S_MNEXT;
         end
         S_MNEXT: begin
            cmd      = CMD_MNEXT;
            state_in = S_MPREV;
         end
         S_MPREV: begin
            cmd      = CMD_MPREV;
            state_in = S_DONE;
         end
         S_QUERY: begin
            cmd      = CMD_QUERY;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_slot_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/vpa_datapath.sv =====
// ----------------------------------------------------------------------------
// vpa_datapath
// Partition table, free-space counter, hole search and result registers.
// ----------------------------------------------------------------------------
module vpa_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  vpa_pkg::cmd_type           cmd,
   input  logic                       rebuild,
   input  logic [1:0]                 fit_mode,
   input  logic [vpa_pkg::SIZE_W-1:0] mem_size,
   input  logic [vpa_pkg::SIZE_W-1:0] in_size,
   input  logic [vpa_pkg::IDX_W-1:0]  in_index,
   output vpa_pkg::dp_sts_type        sts,
   output logic [2:0]                 status,
   output logic [vpa_pkg::IDX_W-1:0]  granted_index,
   output logic [vpa_pkg::SIZE_W-1:0] entry_size,
   output logic                       entry_allocated,
   output logic                       entry_valid,
   output logic [vpa_pkg::CNT_W-1:0]  partition_count,
   output logic [vpa_pkg::SIZE_W-1:0] free_total
);
   import vpa_pkg::*;

   logic [SIZE_W-1:0] size_ff  [MAX_PARTS];
   logic [SIZE_W-1:0] size_in  [MAX_PARTS];
   logic              alloc_ff [MAX_PARTS];
   logic              alloc_in [MAX_PARTS];
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SIZE_W-1:0] free_ff, free_in;
   logic [SIZE_W-1:0] req_ff, req_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [IDX_W-1:0]  ptr_ff, ptr_in;
   logic [IDX_W-1:0]  pick_ff, pick_in;
   logic [SIZE_W-1:0] pick_size_ff, pick_size_in;
   logic              found_ff, found_in;
   logic [SIZE_W-1:0] acc_ff, acc_in;
   logic [2:0]        status_ff, status_in;
   logic [IDX_W-1:0]  granted_ff, granted_in;
   logic [SIZE_W-1:0] esize_ff, esize_in;
   logic              ealloc_ff, ealloc_in;
   logic              evalid_ff, evalid_in;

   logic [IDX_W-1:0]  rd_addr;
   logic [SIZE_W-1:0] rd_size;
   logic              rd_alloc;
   logic [IDX_W-1:0]  idx_next, idx_prev, pick_next;
   logic [SIZE_W-1:0] merged;
   logic              idx_in_range, next_in_range, fits, better;

   assign idx_next  = idx_ff + IDX_W'(1);
   assign idx_prev  = idx_ff - IDX_W'(1);
   assign pick_next = pick_ff + IDX_W'(1);

   // single read port into the table
   always_comb begin
      case (cmd)
         CMD_SCAN:  rd_addr = ptr_ff;
         CMD_MNEXT: rd_addr = idx_next;
         CMD_MPREV: rd_addr = idx_prev;
         default:   rd_addr = idx_ff;
      endcase
   end

   assign rd_size       = size_ff[rd_addr];
   assign rd_alloc      = alloc_ff[rd_addr];
   assign merged        = acc_ff + rd_size;
   assign idx_in_range  = CNT_W'(idx_ff) < count_ff;
   assign next_in_range = (CNT_W'(idx_ff) + CNT_W'(1)) < count_ff;
   assign fits          = !rd_alloc && (rd_size >= req_ff);
   assign better        = !found_ff
                          || (fit_mode == FIT_BEST  && rd_size < pick_size_ff)
                          || (fit_mode == FIT_WORST && rd_size > pick_size_ff);

   assign sts.pre_fail  = (free_ff < req_ff) || (req_ff == '0);
   assign sts.scan_last = (CNT_W'(ptr_ff) + CNT_W'(1)) == count_ff;
   assign sts.found     = found_ff;
   assign sts.exact     = pick_size_ff == req_ff;
   assign sts.full      = count_ff >= CNT_W'(MAX_PARTS);
   assign sts.free_bad  = !idx_in_range || !rd_alloc;

   always_comb begin
      size_in      = size_ff;
      alloc_in     = alloc_ff;
      count_in     = count_ff;
      free_in      = free_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      ptr_in       = ptr_ff;
      pick_in      = pick_ff;
      pick_size_in = pick_size_ff;
      found_in     = found_ff;
      acc_in       = acc_ff;
      status_in    = status_ff;
      granted_in   = granted_ff;
      esize_in     = esize_ff;
      ealloc_in    = ealloc_ff;
      evalid_in    = evalid_ff;
      case (cmd)
         CMD_LOAD: begin
            req_in     = in_size;
            idx_in     = in_index;
            ptr_in     = '0;
            found_in   = 1'b0;
            status_in  = ST_OK;
            granted_in = '0;
            esize_in   = '0;
            ealloc_in  = 1'b0;
            evalid_in  = 1'b0;
         end
         CMD_CHECK: begin
            if (free_ff < req_ff) begin
               status_in = ST_NO_SPACE;
            end else if (req_ff == '0) begin
               status_in = ST_NO_HOLE;
            end
         end
         CMD_SCAN: begin
            if (fits && better) begin
               found_in     = 1'b1;
               pick_in      = ptr_ff;
               pick_size_in = rd_size;
            end
            ptr_in = ptr_ff + IDX_W'(1);
         end
         CMD_RESOLVE: begin
            if (!found_ff) begin
               status_in = ST_NO_HOLE;
            end else if (!sts.exact && sts.full) begin
               status_in = ST_FULL;
            end
         end
         CMD_TAKE: begin
            alloc_in[pick_ff] = 1'b1;
            free_in           = free_ff - req_ff;
            granted_in        = pick_ff;
         end
         CMD_SPLIT: begin
            // open a slot after the hole: allocated piece, then the remainder
            for (int j = 1; j < MAX_PARTS; j++) begin
               if (IDX_W'(j) > pick_next) begin
                  size_in[j]  = size_ff[j-1];
                  alloc_in[j] = alloc_ff[j-1];
               end
            end
            size_in[pick_ff]    = req_ff;
            alloc_in[pick_ff]   = 1'b1;
            size_in[pick_next]  = pick_size_ff - req_ff;
            alloc_in[pick_next] = 1'b0;
            count_in            = count_ff + CNT_W'(1);
            free_in             = free_ff - req_ff;
            granted_in          = pick_ff;
         end
         CMD_FREE: begin
            if (sts.free_bad) begin
               status_in = ST_BAD_INDEX;
            end else begin
               alloc_in[idx_ff] = 1'b0;
               free_in          = free_ff + rd_size;
               acc_in           = rd_size;
            end
         end
         CMD_MNEXT: begin
            // absorb the following free partition and close the gap
            if (next_in_range && !rd_alloc) begin
               for (int j = 0; j < MAX_PARTS - 1; j++) begin
                  if (IDX_W'(j) > idx_ff) begin
                     size_in[j]  = size_ff[j+1];
                     alloc_in[j] = alloc_ff[j+1];
                  end
               end
               size_in[MAX_PARTS-1]  = '0;
               alloc_in[MAX_PARTS-1] = 1'b0;
               size_in[idx_ff]       = merged;
               acc_in                = merged;
               count_in              = count_ff - CNT_W'(1);
            end
         end
         CMD_MPREV: begin
            // fold into the preceding free partition
            if (idx_ff != '0 && !rd_alloc) begin
               for (int j = 0; j < MAX_PARTS - 1; j++) begin
                  if (IDX_W'(j) >= idx_ff) begin
                     size_in[j]  = size_ff[j+1];
                     alloc_in[j] = alloc_ff[j+1];
                  end
               end
               size_in[MAX_PARTS-1]  = '0;
               alloc_in[MAX_PARTS-1] = 1'b0;
               size_in[idx_prev]     = merged;
               count_in              = count_ff - CNT_W'(1);
            end
         end
         CMD_QUERY: begin
            if (idx_in_range) begin
               evalid_in = 1'b1;
               esize_in  = rd_size;
               ealloc_in = rd_alloc;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset || rebuild) begin
         for (int j = 0; j < MAX_PARTS; j++) begin
            if (j == 0) begin
               size_ff[j] <= reset ? MEM_SIZE_RESET : mem_size;
            end else begin
               size_ff[j] <= '0;
            end
            alloc_ff[j] <= 1'b0;
         end
         free_ff    <= reset ? MEM_SIZE_RESET : mem_size;
         count_ff   <= CNT_W'(1);
      end else begin
         size_ff  <= size_in;
         alloc_ff <= alloc_in;
         free_ff  <= free_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      req_ff       <= req_in;
      idx_ff       <= idx_in;
      ptr_ff       <= ptr_in;
      pick_ff      <= pick_in;
      pick_size_ff <= pick_size_in;
      acc_ff       <= acc_in;
      status_ff    <= status_in;
      granted_ff   <= granted_in;
      esize_ff     <= esize_in;
      ealloc_ff    <= ealloc_in;
      evalid_ff    <= evalid_in;
   end

   assign status          = status_ff;
   assign granted_index   = granted_ff;
   assign entry_size      = esize_ff;
   assign entry_allocated = ealloc_ff;
   assign entry_valid     = evalid_ff;
   assign partition_count = count_ff;
   assign free_total      = free_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0 && count_ff <= CNT_W'(MAX_PARTS))
      else $error("partition count out of range");

   a_split_grows: assert property (@(posedge clock) disable iff (reset)
      cmd == CMD_SPLIT && !rebuild |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("split did not add a partition");

   a_pick_in_table: assert property (@(posedge clock) disable iff (reset)
      cmd == CMD_RESOLVE && found_ff |-> CNT_W'(pick_ff) < count_ff)
      else $error("chosen hole lies beyond the table");

endmodule

// ===== rtl/core/variable_partition_allocator_core.sv =====
// ----------------------------------------------------------------------------
// variable_partition_allocator_core
// Variable partition allocator with first, best and worst fit placement.
//
//   Port group  Direction  Carries
//   req_*       in         one request per transfer (func, size, index)
//   rsp_*       out        one result per request
//   csr_*       in/out     fit_mode at 0x0, memory_size at 0x4
//
// Allocate checks space, scans the table (one entry read per scan cycle),
// then takes or splits the hole; free releases the entry and merges it
// with free neighbours; query reads one entry. A new request is taken
// while the previous result waits in the output register; a stalled
// result holds the sequencer in its last step. Reset leaves one free
// partition of 65535 units; writing memory_size rebuilds the table.
// ----------------------------------------------------------------------------
module variable_partition_allocator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // req_size[15:0], part_index[20:16], zero pad
   input  logic [1:0]  req_tuser,   // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // status[2:0], granted_index[7:3],
                                    // entry_size[23:8], entry_allocated[24],
                                    // entry_valid[25], partition_count[31:26],
                                    // free_total[47:32]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import vpa_pkg::*;

   logic [1:0]        fit_mode_ff, fit_mode_in;
   logic [SIZE_W-1:0] mem_size_ff, mem_size_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [47:0]       rsp_data_ff, rsp_data_in;

   logic              csr_wr, rebuild, rsp_load;
   cmd_type           cmd;
   dp_sts_type        sts;
   logic [2:0]        status;
   logic [IDX_W-1:0]  granted_index;
   logic [SIZE_W-1:0] entry_size, free_total;
   logic              entry_allocated, entry_valid;
   logic [CNT_W-1:0]  partition_count;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign rebuild    = csr_wr && (csr_paddr[2] == REG_MEM_SIZE);

   always_comb begin
      fit_mode_in = fit_mode_ff;
      mem_size_in = mem_size_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_FIT_MODE: fit_mode_in = csr_pwdata[1:0];
            REG_MEM_SIZE: mem_size_in = csr_pwdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_FIT_MODE: csr_prdata = {30'd0, fit_mode_ff};
         REG_MEM_SIZE: csr_prdata = {{(32-SIZE_W){1'b0}}, mem_size_ff};
         default:      csr_prdata = '0;
      endcase
   end

   vpa_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_func      (req_tuser),
      .rsp_slot_free (!rsp_valid_ff || rsp_tready),
      .sts           (sts),
      .cmd           (cmd),
      .req_ready     (req_tready),
      .rsp_load      (rsp_load)
   );

   vpa_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .rebuild         (rebuild),
      .fit_mode        (fit_mode_ff),
      .mem_size        (mem_size_in),
      .in_size         (req_tdata[15:0]),
      .in_index        (req_tdata[20:16]),
      .sts             (sts),
      .status          (status),
      .granted_index   (granted_index),
      .entry_size      (entry_size),
      .entry_allocated (entry_allocated),
      .entry_valid     (entry_valid),
      .partition_count (partition_count),
      .free_total      (free_total)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {free_total, partition_count, entry_valid, entry_allocated,
                         entry_size, granted_index, status};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff  <= FIT_FIRST;
         mem_size_ff  <= MEM_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         fit_mode_ff  <= fit_mode_in;
         mem_size_ff  <= mem_size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
